[hdl/assert_macros.svh]
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[hdl/swsl_pkg.sv]
// Shared types and constants of the sliding window spam limiter.
// No dependencies.
package swsl_pkg;
  // user count and log depth are fixed; log addressing relies on powers of two
  localparam int NumUsers = 256;
  localparam int LogDepth = 16;

  localparam logic [2:0] ReasonNone      = 3'd0;
  localparam logic [2:0] ReasonMuted     = 3'd1;
  localparam logic [2:0] ReasonBanned    = 3'd2;
  localparam logic [2:0] ReasonNewMute   = 3'd3;
  localparam logic [2:0] ReasonNewBan    = 3'd4;

  localparam logic [2:0] RegWindow  = 3'd0;
  localparam logic [2:0] RegMsgThr  = 3'd1;
  localparam logic [2:0] RegBanThr  = 3'd2;
  localparam logic [2:0] RegMuteSec = 3'd3;
  localparam logic [2:0] RegBanSec  = 3'd4;

  typedef struct packed {
    logic       sender_muted;
    logic       sender_banned;
    logic       escalated;
    logic       escalated_to_ban;
    logic [2:0] reason_code;
  } result_t;
endpackage

[hdl/sliding_window_spam_limiter_unit.sv]
// Sliding window spam limiter: per-user message log, mute and ban state.
// Depends on swsl_pkg.
//
// Use: items enter on s_axis (tdata = user_id, now_seconds, is_guest from bit 0
// up); one result per item leaves on m_axis (tdata = sender_muted,
// sender_banned, escalated, escalated_to_ban, reason_code). The user must write
// registers over the APB port only while the block is idle (not enforced).
// Per-user records sit in a user memory; the logged times sit in a second
// memory of USERS*LOG_DEPTH words. An item reads the user record, then walks
// the log head one entry per cycle to drop stale times, then writes back. A
// guest's result follows the read with no write-back; a blocked message
// skips the walk.
// Items are handled one at a time; the next is accepted the cycle after the
// result is taken. A stalled receiver holds the result and blocks the input.
// Reset: registers take their defaults. A clearing pass sweeps the user
// memory, zeroing every entry, before the first item is taken.
// The log memory needs no clear: only entries inside a user's count are used.
module sliding_window_spam_limiter_unit #(
  parameter int TIME_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // user_id[7:0], now_seconds[39:8], is_guest[40]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // muted, banned, escalated, to_ban, reason[6:4]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int USERS     = swsl_pkg::NumUsers;
  localparam int LOG_DEPTH = swsl_pkg::LogDepth;
  localparam int UB = (USERS > 1) ? $clog2(USERS) : 1;
  localparam int LB = $clog2(LOG_DEPTH);
  localparam int CB = $clog2(LOG_DEPTH + 1);
  localparam int TB = TIME_BITS;
  localparam logic [TB-1:0] TimeMax = '1;

  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StRead  = 3'd2;
  localparam logic [2:0] StWalk  = 3'd3;
  localparam logic [2:0] StWrite = 3'd4;

  typedef struct packed {
    logic          mute_act;
    logic [TB-1:0] mute_exp;
    logic          ban_act;
    logic [TB-1:0] ban_exp;
    logic [7:0]    viol;
    logic [CB-1:0] cnt;
    logic [LB-1:0] head;
  } user_rec_t;

  // configuration
  logic [15:0] window_q, mute_sec_q, ban_sec_q;
  logic [3:0]  msg_thr_q;
  logic [7:0]  ban_thr_q;
  logic        wr_en;
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q   <= 16'd10;
      msg_thr_q  <= 4'd5;
      ban_thr_q  <= 8'd3;
      mute_sec_q <= 16'd60;
      ban_sec_q  <= 16'd600;
    end else if (wr_en && paddr[1:0] == 2'd0) begin
      unique case (paddr[4:2])
        swsl_pkg::RegWindow:  window_q   <= pwdata[15:0];
        swsl_pkg::RegMsgThr:  msg_thr_q  <= pwdata[3:0];
        swsl_pkg::RegBanThr:  ban_thr_q  <= pwdata[7:0];
        swsl_pkg::RegMuteSec: mute_sec_q <= pwdata[15:0];
        swsl_pkg::RegBanSec:  ban_sec_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      swsl_pkg::RegWindow:  prdata = {16'd0, window_q};
      swsl_pkg::RegMsgThr:  prdata = {28'd0, msg_thr_q};
      swsl_pkg::RegBanThr:  prdata = {24'd0, ban_thr_q};
      swsl_pkg::RegMuteSec: prdata = {16'd0, mute_sec_q};
      swsl_pkg::RegBanSec:  prdata = {16'd0, ban_sec_q};
      default:              prdata = 32'd0;
    endcase
  end

  // memories
  user_rec_t     user_mem [USERS];
  logic [TB-1:0] log_mem  [USERS*LOG_DEPTH];
  user_rec_t     urd_q;
  logic [TB-1:0] lrd_q;
  logic          u_we, l_we;
  logic [UB-1:0] u_waddr, u_raddr;
  user_rec_t     u_wdata;
  logic [UB+LB-1:0] l_waddr, l_raddr;
  logic [TB-1:0] l_wdata;

  always_ff @(posedge clk_i) begin
    if (u_we) user_mem[u_waddr] <= u_wdata;
    urd_q <= user_mem[u_raddr];
  end
  always_ff @(posedge clk_i) begin
    if (l_we) log_mem[l_waddr] <= l_wdata;
    lrd_q <= log_mem[l_raddr];
  end

  // control
  logic [2:0]    state_q, state_d;
  logic [UB:0]   clr_q, clr_d;
  logic [UB-1:0] user_q, user_d;
  logic [TB-1:0] now_q, now_d, cutoff_q, cutoff_d;
  logic          guest_q, guest_d;
  user_rec_t     rec_q, rec_d;
  logic          out_vld_q, out_vld_d;
  swsl_pkg::result_t res_q, res_d;

  logic          accept;
  logic [TB-1:0] in_now;
  logic [UB-1:0] in_user;
  logic [LB-1:0] head_nx;
  logic [TB:0]   mute_sum, ban_sum;
  logic [TB-1:0] mute_sat, ban_sat;
  logic [8:0]    viol_inc;
  logic [CB-1:0] cnt_new;
  logic [LB-1:0] head_new;
  logic [LB:0]   tail_sum;
  logic [UB+LB-1:0] slot_base;

  assign s_axis_tready = (state_q == StIdle) && !out_vld_q;
  assign accept  = s_axis_tvalid & s_axis_tready;
  assign in_user = UB'(s_axis_tdata[7:0]);
  assign in_now  = TB'(s_axis_tdata[39:8]);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, res_q.reason_code, res_q.escalated_to_ban,
                          res_q.escalated, res_q.sender_banned, res_q.sender_muted};

  assign head_nx   = (rec_q.head == LB'(LOG_DEPTH - 1)) ? '0 : rec_q.head + 1'b1;
  assign mute_sum  = {1'b0, now_q} + (TB+1)'(mute_sec_q);
  assign ban_sum   = {1'b0, now_q} + (TB+1)'(ban_sec_q);
  assign mute_sat  = mute_sum[TB] ? TimeMax : mute_sum[TB-1:0];
  assign ban_sat   = ban_sum[TB] ? TimeMax : ban_sum[TB-1:0];
  assign tail_sum  = {1'b0, rec_q.head} + (LB+1)'(rec_q.cnt);
  assign slot_base = {user_q, {LB{1'b0}}};

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    user_d    = user_q;
    now_d     = now_q;
    cutoff_d  = cutoff_q;
    guest_d   = guest_q;
    rec_d     = rec_q;
    res_d     = res_q;
    out_vld_d = out_vld_q && !m_axis_tready;
    u_we      = 1'b0;
    u_waddr   = user_q;
    u_wdata   = rec_q;
    u_raddr   = in_user;
    l_we      = 1'b0;
    l_waddr   = slot_base;
    l_wdata   = now_q;
    l_raddr   = slot_base | (UB+LB)'(rec_q.head);
    viol_inc  = {1'b0, rec_q.viol} + 9'd1;
    cnt_new   = '0;
    head_new  = '0;
    unique case (state_q)
      StClear: begin
        u_we    = 1'b1;
        u_waddr = clr_q[UB-1:0];
        u_wdata = '0;
        clr_d   = clr_q + 1'b1;
        if (clr_q == (UB+1)'(USERS - 1)) state_d = StIdle;
      end
      StIdle: begin
        if (accept) begin
          user_d   = in_user;
          now_d    = in_now;
          guest_d  = s_axis_tdata[40];
          cutoff_d = (in_now > TB'(window_q)) ? in_now - TB'(window_q) : '0;
          state_d  = StRead;
        end
      end
      StRead: begin
        rec_d = urd_q;
        res_d = '0;
        if (guest_q) begin
          out_vld_d = 1'b1;
          state_d   = StIdle;
        end else begin
          if (urd_q.mute_act) begin
            if (urd_q.mute_exp <= now_q) rec_d.mute_act = 1'b0;
            else res_d.sender_muted = 1'b1;
          end
          if (urd_q.ban_act) begin
            if (urd_q.ban_exp <= now_q) rec_d.ban_act = 1'b0;
            else res_d.sender_banned = 1'b1;
          end
          if (res_d.sender_banned) res_d.reason_code = swsl_pkg::ReasonBanned;
          else if (res_d.sender_muted) res_d.reason_code = swsl_pkg::ReasonMuted;
          if (res_d.sender_banned || res_d.sender_muted) begin
            state_d = StWrite;
          end else begin
            state_d = StWalk;
          end
          // fetch oldest logged time
          l_raddr = slot_base | (UB+LB)'(urd_q.head);
        end
      end
      StWalk: begin
        // lrd_q holds the time at rec_q.head
        if (rec_q.cnt != '0 && lrd_q < cutoff_q) begin
          rec_d.head = head_nx;
          rec_d.cnt  = rec_q.cnt - 1'b1;
          l_raddr    = slot_base | (UB+LB)'(head_nx);
        end else begin
          state_d = StWrite;
          if (rec_q.cnt >= CB'(LOG_DEPTH)) begin
            l_waddr  = slot_base | (UB+LB)'(rec_q.head);
            head_new = head_nx;
            cnt_new  = CB'(LOG_DEPTH);
          end else begin
            l_waddr  = slot_base | (UB+LB)'(tail_sum[LB-1:0]);
            head_new = rec_q.head;
            cnt_new  = rec_q.cnt + 1'b1;
          end
          l_we       = 1'b1;
          rec_d.head = head_new;
          rec_d.cnt  = cnt_new;
          if (cnt_new > CB'(msg_thr_q)) begin
            rec_d.cnt  = '0;
            rec_d.head = '0;
            if (rec_q.viol != 8'hFF) rec_d.viol = viol_inc[7:0];
            res_d.escalated = 1'b1;
            if (rec_d.viol >= ban_thr_q) begin
              res_d.escalated_to_ban = 1'b1;
              res_d.reason_code      = swsl_pkg::ReasonNewBan;
              rec_d.ban_act          = 1'b1;
              rec_d.ban_exp          = ban_sat;
            end else begin
              res_d.reason_code = swsl_pkg::ReasonNewMute;
              rec_d.mute_act    = 1'b1;
              rec_d.mute_exp    = mute_sat;
            end
          end
        end
      end
      StWrite: begin
        u_we      = 1'b1;
        out_vld_d = 1'b1;
        state_d   = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StClear;
      clr_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    user_q   <= user_d;
    now_q    <= now_d;
    cutoff_q <= cutoff_d;
    guest_q  <= guest_d;
    rec_q    <= rec_d;
    res_q    <= res_d;
  end
endmodule

[hdl/swsl_checker.sv]
// Port-level checks for the spam limiter.
// Depends on assert_macros.svh; bound to sliding_window_spam_limiter_unit.
`include "assert_macros.svh"
module swsl_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output item dropped or changed while stalled")
  `ASSERT_NEXT(a_no_accept_run, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second item accepted during work")
  `ASSERT_IMPL(a_ready_only_empty, clk_i, rst_ni, s_axis_tready, !m_axis_tvalid, "item accepted while result still pending")
  `ASSERT_IMPL(a_esc_reason, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[2], m_axis_tdata[6:4] == 3'd3 || m_axis_tdata[6:4] == 3'd4, "escalation without matching reason")
  `ASSERT_IMPL(a_block_no_esc, clk_i, rst_ni, m_axis_tvalid && (m_axis_tdata[0] || m_axis_tdata[1]), !m_axis_tdata[2], "blocked item escalated")
endmodule

bind sliding_window_spam_limiter_unit swsl_checker u_swsl_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
